### sv/dpb_pkg.sv
// Shared types, register indexes and field widths for the depth back-projection block.
package dpb_pkg;

    // Field widths that the register map and the pixel format fix
    localparam int DIM_W      = 13;
    localparam int CENTER_W   = 16;
    localparam int INV_W      = 24;
    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FRAC_SHIFT = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

    // Register values after reset
    localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5112;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3832;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd31957;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd31957;

    // One incoming depth pixel with its colour
    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } t_pixel;

    // One back-projected point
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      point_valid;
        logic [7:0]                out_blue;
        logic [7:0]                out_green;
        logic [7:0]                out_red;
        logic                      end_of_frame;
    } t_point;

    // Classified pixel handed from the front end to the multiply pipeline
    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic               point_valid;
        logic               neg_x;
        logic               neg_y;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic               end_of_frame;
    } t_job_meta;

endpackage

### sv/dpb_fifo.sv
// Small first-word-fall-through queue with an occupancy count.
module dpb_fifo
    import dpb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_pop && !o_empty;

    // Advance pointers (wrapping at the last entry) and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/dpb_front.sv
// Front end: pixel position counters and classification of each accepted pixel.
module dpb_front
    import dpb_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int MAG_W   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_queue_full,
    input  t_pixel              i_pixel,
    input  logic [DIM_W-1:0]    i_image_width,
    input  logic [DIM_W-1:0]    i_image_height,
    input  logic [CENTER_W-1:0] i_center_x,
    input  logic [CENTER_W-1:0] i_center_y,
    output logic                o_write,
    output t_job_meta           o_meta,
    output logic [MAG_W-1:0]    o_mag_x,
    output logic [MAG_W-1:0]    o_mag_y
);
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam logic [DW-1:0] MAX_D = DW'(MAX_DIM);

    logic [CW-1:0] r_column, n_column;
    logic [CW-1:0] r_row, n_row;
    logic [DW-1:0] width_c, height_c;
    logic [DW-1:0] col_next, row_next;
    logic          last_col, last_row;
    logic [MAG_W-1:0] pos_x, pos_y, cen_x, cen_y;
    logic          neg_x, neg_y;

    assign o_write = i_push && !i_queue_full;

    // Clamp the frame size to 1..MAX_DIM
    always_comb begin
        if (i_image_width == '0) begin
            width_c = DW'(1);
        end else if (DW'(i_image_width) > MAX_D) begin
            width_c = MAX_D;
        end else begin
            width_c = DW'(i_image_width);
        end
        if (i_image_height == '0) begin
            height_c = DW'(1);
        end else if (DW'(i_image_height) > MAX_D) begin
            height_c = MAX_D;
        end else begin
            height_c = DW'(i_image_height);
        end
    end

    assign col_next = DW'(r_column) + DW'(1);
    assign row_next = DW'(r_row) + DW'(1);
    assign last_col = (col_next >= width_c);
    assign last_row = (row_next >= height_c);

    // Offset from the principal point in 1/16 pixel, as sign and magnitude
    assign pos_x = MAG_W'({r_column, 4'b0000});
    assign pos_y = MAG_W'({r_row, 4'b0000});
    assign cen_x = MAG_W'(i_center_x);
    assign cen_y = MAG_W'(i_center_y);
    assign neg_x = (pos_x < cen_x);
    assign neg_y = (pos_y < cen_y);
    assign o_mag_x = neg_x ? cen_x - pos_x : pos_x - cen_x;
    assign o_mag_y = neg_y ? cen_y - pos_y : pos_y - cen_y;

    always_comb begin
        o_meta.depth_mm     = i_pixel.depth_mm;
        o_meta.point_valid  = (i_pixel.depth_mm != '0);
        o_meta.neg_x        = neg_x;
        o_meta.neg_y        = neg_y;
        o_meta.blue         = i_pixel.blue;
        o_meta.green        = i_pixel.green;
        o_meta.red          = i_pixel.red;
        o_meta.end_of_frame = last_col && last_row;
    end

    // Advance raster position on each accepted request
    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        if (o_write) begin
            if (last_col) begin
                n_column = '0;
                n_row    = last_row ? '0 : CW'(row_next);
            end else begin
                n_column = CW'(col_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

endmodule

### sv/dpb_back.sv
// Back end: two-stage multiply pipeline with rounding and saturation of the coordinates.
module dpb_back
    import dpb_pkg::*;
#(
    parameter int MAG_W     = 16,
    parameter int OUT_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_empty,
    output logic                        o_job_pop,
    input  t_job_meta                   i_meta,
    input  logic [MAG_W-1:0]            i_mag_x,
    input  logic [MAG_W-1:0]            i_mag_y,
    input  logic [INV_W-1:0]            i_inv_focal_x,
    input  logic [INV_W-1:0]            i_inv_focal_y,
    input  logic [$clog2(OUT_DEPTH):0]  i_out_count,
    output logic                        o_out_push,
    output t_point                      o_point
);
    localparam int CNT_W = $clog2(OUT_DEPTH) + 1;
    localparam int P1_W  = DEPTH_W + MAG_W;
    localparam int P2_W  = P1_W + INV_W;
    localparam int RW    = P2_W + 1 - FRAC_SHIFT;
    localparam logic [P2_W:0]   HALF_LSB = (P2_W + 1)'(1) << (FRAC_SHIFT - 1);
    localparam logic [RW-1:0]   NEG_LIMIT = RW'(33'h0_8000_0000);
    localparam logic [RW-1:0]   POS_LIMIT = RW'(33'h0_7FFF_FFFF);

    logic                r_s1_valid, r_s2_valid;
    t_job_meta           r_s1_meta, r_s2_meta;
    logic [P1_W-1:0]     r_s1_px, r_s1_py;
    logic [P2_W-1:0]     r_s2_px, r_s2_py;
    logic [CNT_W:0]      committed;

    // Round to nearest (ties away from zero), apply sign, saturate to 32 bits
    function automatic logic [COORD_W-1:0] round_sat(input logic [P2_W-1:0] prod,
                                                      input logic neg);
        logic [P2_W:0]        sum;
        logic [RW-1:0]        mag;
        logic [COORD_W-1:0]   res;
        sum = {1'b0, prod} + HALF_LSB;
        mag = sum[P2_W:FRAC_SHIFT];
        if (neg) begin
            res = (mag > NEG_LIMIT) ? 32'h8000_0000 : mag[COORD_W-1:0];
            res = 32'd0 - res;
        end else begin
            res = (mag > POS_LIMIT) ? 32'h7FFF_FFFF : mag[COORD_W-1:0];
        end
        return res;
    endfunction

    // Issue only when the result queue has room for everything in flight
    assign committed = (CNT_W + 1)'(i_out_count) + (CNT_W + 1)'(r_s1_valid)
                     + (CNT_W + 1)'(r_s2_valid);
    assign o_job_pop = !i_job_empty && (committed < (CNT_W + 1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_job_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 1: depth times offset
    always_ff @(posedge i_clk) begin
        r_s1_meta <= i_meta;
        r_s1_px   <= P1_W'(i_meta.depth_mm) * P1_W'(i_mag_x);
        r_s1_py   <= P1_W'(i_meta.depth_mm) * P1_W'(i_mag_y);
    end

    // Stage 2: scale by reciprocal focal length
    always_ff @(posedge i_clk) begin
        r_s2_meta      <= r_s1_meta;
        r_s2_px        <= P2_W'(r_s1_px) * P2_W'(i_inv_focal_x);
        r_s2_py        <= P2_W'(r_s1_py) * P2_W'(i_inv_focal_y);
    end

    // Assemble the result; zero depth gives zero products and so zero coordinates
    assign o_out_push = r_s2_valid;
    always_comb begin
        o_point.point_x      = round_sat(r_s2_px, r_s2_meta.neg_x);
        o_point.point_y      = round_sat(r_s2_py, r_s2_meta.neg_y);
        o_point.point_z      = r_s2_meta.depth_mm;
        o_point.point_valid  = r_s2_meta.point_valid;
        o_point.out_blue     = r_s2_meta.blue;
        o_point.out_green    = r_s2_meta.green;
        o_point.out_red      = r_s2_meta.red;
        o_point.end_of_frame = r_s2_meta.end_of_frame;
    end

endmodule

### sv/depth_to_point_backprojection.sv
// Top level of the pinhole depth-image to point-cloud back-projection block.
// Throughput: one pixel per cycle, sustained while pop keeps pace with push.
// Path: a pushed pixel passes the job queue, the depth-times-offset multiply,
//   the reciprocal-focal multiply and the result queue to reach the result ports.
// Reset (synchronous, i_rst_n low): queues empty, counters at the first pixel,
//   configuration registers back to their power-on values.
module depth_to_point_backprojection
    import dpb_pkg::*;
#(
    parameter int MAX_DIM     = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_pixel                i_pixel,
    output logic                  full,
    input  logic                  pop,
    output t_point                o_point,
    output logic                  empty,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW     = $clog2(MAX_DIM);
    localparam int MAG_W  = (CW + 4 > CENTER_W) ? CW + 4 : CENTER_W;
    localparam int META_W = $bits(t_job_meta);
    localparam int JOB_W  = META_W + 2 * MAG_W;
    localparam int PT_W   = $bits(t_point);
    localparam int QC_W   = $clog2(QUEUE_DEPTH) + 1;

    logic [DIM_W-1:0]    r_image_width, r_image_height;
    logic [CENTER_W-1:0] r_center_x, r_center_y;
    logic [INV_W-1:0]    r_inv_focal_x, r_inv_focal_y;

    logic             job_write, job_full, job_empty, job_pop;
    t_job_meta        front_meta, job_meta;
    logic [MAG_W-1:0] front_mag_x, front_mag_y, job_mag_x, job_mag_y;
    logic [JOB_W-1:0] job_in, job_out;
    logic [QC_W-1:0]  job_count, out_count;
    logic             out_push, out_full;
    t_point           back_point;
    logic [PT_W-1:0]  out_data;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_center_x     <= RST_CENTER_X;
            r_center_y     <= RST_CENTER_Y;
            r_inv_focal_x  <= RST_INV_FOCAL_X;
            r_inv_focal_y  <= RST_INV_FOCAL_Y;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                REG_CENTER_X:     r_center_x     <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:     r_center_y     <= i_cfg_data[CENTER_W-1:0];
                REG_INV_FOCAL_X:  r_inv_focal_x  <= i_cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:  r_inv_focal_y  <= i_cfg_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dpb_front #(
        .MAX_DIM (MAX_DIM),
        .MAG_W   (MAG_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_queue_full   (job_full),
        .i_pixel        (i_pixel),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_center_x     (r_center_x),
        .i_center_y     (r_center_y),
        .o_write        (job_write),
        .o_meta         (front_meta),
        .o_mag_x        (front_mag_x),
        .o_mag_y        (front_mag_y)
    );

    assign full   = job_full;
    assign job_in = {front_meta, front_mag_x, front_mag_y};

    // Queue between classification and the multiply pipeline
    dpb_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_write),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    assign job_meta  = t_job_meta'(job_out[JOB_W-1 -: META_W]);
    assign job_mag_x = job_out[2*MAG_W-1 -: MAG_W];
    assign job_mag_y = job_out[MAG_W-1:0];

    dpb_back #(
        .MAG_W     (MAG_W),
        .OUT_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (job_empty),
        .o_job_pop     (job_pop),
        .i_meta        (job_meta),
        .i_mag_x       (job_mag_x),
        .i_mag_y       (job_mag_y),
        .i_inv_focal_x (r_inv_focal_x),
        .i_inv_focal_y (r_inv_focal_y),
        .i_out_count   (out_count),
        .o_out_push    (out_push),
        .o_point       (back_point)
    );

    // Result queue that decouples the pipeline from the consumer
    dpb_fifo #(
        .WIDTH (PT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_point),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_point = t_point'(out_data);

    // The pipeline never pushes into a full result queue
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_push && out_full))
        else $error("result pushed into full queue");

    // The pipeline only takes a request from a non-empty job queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> (!job_empty && job_count != '0))
        else $error("job taken from empty queue");

    // An accepted pixel is waiting in the job queue on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !job_empty)
        else $error("accepted pixel lost");

    // A point without depth has zero coordinates
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_point.point_valid) |->
            (o_point.point_x == 0 && o_point.point_y == 0 && o_point.point_z == 0))
        else $error("invalid point carries coordinates");

endmodule

### dv/depth_to_point_backprojection_checker.sv
`timescale 1ns / 100ps
// Predictor and scoreboard that watch the pixel, point and register channels of the block.
module depth_to_point_backprojection_checker
    import dpb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_pixel                i_pixel,
    input  logic                  i_full,
    input  logic                  i_pop,
    input  t_point                i_point,
    input  logic                  i_empty,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Shadow copy of the camera registers and the raster position
    logic [DIM_W-1:0]    img_width;
    logic [DIM_W-1:0]    img_height;
    logic [CENTER_W-1:0] ctr_x;
    logic [CENTER_W-1:0] ctr_y;
    logic [INV_W-1:0]    inv_fx;
    logic [INV_W-1:0]    inv_fy;
    int unsigned         col_pos;
    int unsigned         row_pos;

    t_point expected_points[$];
    int     fails = 0;

    // Zero size behaves as one, oversize as the largest frame
    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] n);
        if (n == '0) return 1;
        if (n > MAX_DIM) return MAX_DIM;
        return n;
    endfunction

    // Scale the offset from the principal point by depth and 1/f, round half away
    // from zero and saturate to the signed coordinate range
    function automatic logic [COORD_W-1:0] back_project(logic [DEPTH_W-1:0] depth,
            int unsigned pos, logic [CENTER_W-1:0] center, logic [INV_W-1:0] inv);
        logic [63:0] pos16;
        logic [63:0] offset;
        logic [63:0] prod;
        logic [63:0] mag;
        logic        neg;
        pos16  = 64'(pos) << 4;
        neg    = pos16 < 64'(center);
        offset = neg ? 64'(center) - pos16 : pos16 - 64'(center);
        prod   = 64'(depth) * offset * 64'(inv);
        mag    = (prod + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return -mag[COORD_W-1:0];
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[COORD_W-1:0];
    endfunction

    task automatic check_field(string name, logic [COORD_W-1:0] want,
            logic [COORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        int unsigned w;
        int unsigned h;
        logic        at_col_end;
        logic        at_row_end;
        t_point      want;
        if (!i_rst_n) begin
            img_width  = RST_IMAGE_WIDTH;
            img_height = RST_IMAGE_HEIGHT;
            ctr_x      = RST_CENTER_X;
            ctr_y      = RST_CENTER_Y;
            inv_fx     = RST_INV_FOCAL_X;
            inv_fy     = RST_INV_FOCAL_Y;
            col_pos    = 0;
            row_pos    = 0;
            expected_points.delete();
        end else begin
            // Compare the point taken at this edge with the oldest prediction
            if (i_pop && !i_empty) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: point expected none got %h", $time, i_point);
                    fails++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("point_x", want.point_x, i_point.point_x);
                    check_field("point_y", want.point_y, i_point.point_y);
                    check_field("point_z", want.point_z, i_point.point_z);
                    check_field("point_valid", want.point_valid, i_point.point_valid);
                    check_field("out_blue", want.out_blue, i_point.out_blue);
                    check_field("out_green", want.out_green, i_point.out_green);
                    check_field("out_red", want.out_red, i_point.out_red);
                    check_field("end_of_frame", want.end_of_frame, i_point.end_of_frame);
                end
            end

            // Mirror register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  img_width  = i_cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: img_height = i_cfg_data[DIM_W-1:0];
                    REG_CENTER_X:     ctr_x      = i_cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:     ctr_y      = i_cfg_data[CENTER_W-1:0];
                    REG_INV_FOCAL_X:  inv_fx     = i_cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y:  inv_fy     = i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end

            // Predict the point for an accepted pixel request and advance the raster
            if (i_push && !i_full) begin
                w          = clamp_dim(img_width);
                h          = clamp_dim(img_height);
                at_col_end = col_pos + 1 >= w;
                at_row_end = row_pos + 1 >= h;
                want       = '0;
                if (i_pixel.depth_mm != '0) begin
                    want.point_x     = back_project(i_pixel.depth_mm, col_pos, ctr_x, inv_fx);
                    want.point_y     = back_project(i_pixel.depth_mm, row_pos, ctr_y, inv_fy);
                    want.point_z     = i_pixel.depth_mm;
                    want.point_valid = 1'b1;
                end
                want.out_blue     = i_pixel.blue;
                want.out_green    = i_pixel.green;
                want.out_red      = i_pixel.red;
                want.end_of_frame = at_col_end && at_row_end;
                expected_points.insert(expected_points.size(), want);
                if (at_col_end) begin
                    col_pos = 0;
                    row_pos = at_row_end ? 0 : row_pos + 1;
                end else begin
                    col_pos = col_pos + 1;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
    end

endmodule

### dv/depth_to_point_backprojection_test.sv
`timescale 1ns / 100ps
// Testbench top: drives pixel and register traffic into the back-projection block.
module depth_to_point_backprojection_test;
    import dpb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 150;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  push      = 1'b0;
    t_pixel                pixel_in  = '0;
    logic                  full;
    logic                  pop       = 1'b0;
    t_point                point_out;
    logic                  empty;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;
    bit                    idle_on   = 1'b1;
    int                    recv_hold = 0;

    depth_to_point_backprojection dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_pixel    (pixel_in),
        .full       (full),
        .pop        (pop),
        .o_point    (point_out),
        .empty      (empty),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    depth_to_point_backprojection_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (pixel_in),
        .i_full      (full),
        .i_pop       (pop),
        .i_point     (point_out),
        .i_empty     (empty),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 13) : 0;
    endfunction

    function automatic t_pixel make_pixel(logic [DEPTH_W-1:0] depth, logic [7:0] b,
            logic [7:0] g, logic [7:0] r);
        t_pixel px;
        px.depth_mm = depth;
        px.blue     = b;
        px.green    = g;
        px.red      = r;
        return px;
    endfunction

    // Mostly full-range depth, with a share of no-measurement and near-maximum values
    function automatic t_pixel rand_pixel();
        t_pixel px;
        case ($urandom_range(0, 9))
            0:       px.depth_mm = '0;
            1:       px.depth_mm = '1;
            2:       px.depth_mm = 16'($urandom_range(60000, 65535));
            default: px.depth_mm = 16'($urandom);
        endcase
        px.blue  = 8'($urandom);
        px.green = 8'($urandom);
        px.red   = 8'($urandom);
        return px;
    endfunction

    // Frame size with junk above the register width
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        logic [DIM_W-1:0] n;
        case ($urandom_range(0, 9))
            0:       n = '0;
            1:       n = 13'd4096;
            2:       n = 13'd5000;
            3:       n = '1;
            4:       n = 13'($urandom_range(9, 64));
            default: n = 13'($urandom_range(1, 8));
        endcase
        return {11'($urandom), n};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        logic [CENTER_W-1:0] c;
        case ($urandom_range(0, 5))
            0:       c = '0;
            1:       c = '1;
            default: c = 16'($urandom);
        endcase
        return {8'($urandom), c};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_inv();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 24'd1;
            2:       return '1;
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one pixel request after a gap and hold it until taken
    task automatic send_pixel(t_pixel px, int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        pixel_in <= px;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering and wait until every predicted point has come out
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_camera(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] height,
            logic [CFG_DATA_W-1:0] cx, logic [CFG_DATA_W-1:0] cy,
            logic [CFG_DATA_W-1:0] ifx, logic [CFG_DATA_W-1:0] ify);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_INV_FOCAL_X, ifx);
        write_reg(REG_INV_FOCAL_Y, ify);
        cfg_we <= 1'b0;
    endtask

    // Point side: random wait before each request, long hold-off on demand
    initial begin : receiver
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (recv_hold > 0) begin
                gap       = recv_hold;
                recv_hold = 0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // End the run when neither side moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || !i_rst_n) quiet = 0;
            else quiet++;
        end
        $display("FAIL depth_to_point_backprojection");
        $finish;
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Power-on camera: no measurement, extreme depths and colors
        send_pixel(make_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF), 0);
        send_pixel(make_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00), draw_gap());
        send_pixel(make_pixel(16'd1, 8'h55, 8'hAA, 8'h0F), draw_gap());
        send_pixel(rand_pixel(), draw_gap());

        // Tiny frame, extreme principal point and focal lengths, saturating x
        drain();
        load_camera(24'd3, 24'd2, 24'hFFFF, 24'd0, 24'hFFFFFF, 24'd1);
        send_pixel(make_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56), 0);
        send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF), 0);
        send_pixel(make_pixel(16'hFFFF, 8'h00, 8'hFF, 8'h00), draw_gap());
        send_pixel(make_pixel(16'd0, 8'h80, 8'h01, 8'h7F), draw_gap());
        send_pixel(make_pixel(16'hFFFF, 8'h01, 8'h02, 8'h03), draw_gap());
        send_pixel(make_pixel(16'd1, 8'hFE, 8'hFD, 8'hFC), draw_gap());
        send_pixel(make_pixel(16'd40000, 8'h00, 8'h00, 8'h00), draw_gap());

        // Zero width counts as one; height has bits above the register masked off
        drain();
        load_camera({11'h7FF, 13'd0}, 24'h002002, 24'd0, 24'hFFFF, 24'd1, 24'hFFFFFF);
        repeat (3) send_pixel(rand_pixel(), draw_gap());

        // Shrink the frame under a running raster, then poke an unused index
        drain();
        load_camera(24'd8, 24'd4, 24'd64, 24'd32, 24'd31957, 24'd31957);
        repeat (5) send_pixel(rand_pixel(), draw_gap());
        drain();
        write_reg(REG_IMAGE_WIDTH, 24'd2);
        write_reg(REG_IMAGE_HEIGHT, 24'd1);
        write_reg(REG_UNUSED, 24'hABCDEF);
        cfg_we <= 1'b0;
        repeat (3) send_pixel(rand_pixel(), draw_gap());

        // Back up the block: receiver holds off while requests keep coming
        drain();
        idle_on   = 1'b1;
        recv_hold = LONG_HOLD;
        repeat (30) send_pixel(rand_pixel(), 0);

        // Random cameras, each followed by a burst of random pixels
        repeat (5) begin
            drain();
            load_camera(pick_dim(), pick_dim(), pick_center(), pick_center(),
                        pick_inv(), pick_inv());
            idle_on = $urandom_range(0, 3) != 0;
            repeat (100) send_pixel(rand_pixel(), draw_gap());
        end

        // Row from the left edge with maximum 1/fx
        drain();
        write_reg(REG_IMAGE_WIDTH, 24'd1);
        write_reg(REG_IMAGE_HEIGHT, 24'd1);
        cfg_we <= 1'b0;
        send_pixel(rand_pixel(), 0);
        drain();
        load_camera(24'd4096, pick_dim(), 24'd0, pick_center(), 24'hFFFFFF, pick_inv());
        for (int i = 0; i < 50; i++) begin
            idle_on = ((i / 25) % 2) == 0;
            send_pixel(rand_pixel(), draw_gap());
        end

        drain();
        if (fail_count == 0) begin
            $display("PASS depth_to_point_backprojection");
        end else begin
            $display("FAIL depth_to_point_backprojection");
        end
        $finish;
    end

endmodule
